FILE: rtl/core/olad_pkg.sv
package olad_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } olad_status_e;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_DELETE = 1'b1
  } olad_cmd_e;

  typedef struct packed {
    olad_cmd_e               cmd;
    logic signed [VAL_W-1:0] value;
  } olad_in_t;

  typedef struct packed {
    olad_status_e            status;
    logic [LEN_W-1:0]        length;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] tail_value;
  } olad_out_t;

endpackage

FILE: rtl/core/olad_ram.sv
module olad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/olad_seq.sv
module olad_seq #(
  parameter int unsigned CAPACITY = olad_pkg::DEF_CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  olad_pkg::olad_in_t cmd_word_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output olad_pkg::olad_out_t res_word_o
);

  import olad_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_WALK,
    S_FIX,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [SW-1:0]           head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [CW-1:0]           count_q, count_d, fcnt_q, fcnt_d, hw_q, hw_d, pos_q, pos_d;
  logic signed [VAL_W-1:0] val_q, val_d, head_val_q, head_val_d, tail_val_q, tail_val_d;
  olad_status_e            status_q, status_d;
  logic                    fix_head_q, fix_head_d;

  // node store and free slot stack
  logic                    val_we, nxt_we, prv_we, fs_we;
  logic [SW-1:0]           val_waddr, nxt_waddr, prv_waddr, rd_addr;
  logic [SW-1:0]           nxt_wdata, prv_wdata;
  logic signed [VAL_W-1:0] val_rd;
  logic [SW-1:0]           nxt_rd, prv_rd, fs_rd, fs_raddr, alloc_slot;
  logic [CW-1:0]           count_m1;
  logic                    match, is_first, is_last;

  olad_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_q),
    .raddr_i(rd_addr),
    .rdata_o(val_rd)
  );

  olad_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_nxt (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(nxt_waddr),
    .wdata_i(nxt_wdata),
    .raddr_i(rd_addr),
    .rdata_o(nxt_rd)
  );

  olad_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prv (
    .clk_i  (clk_i),
    .we_i   (prv_we),
    .waddr_i(prv_waddr),
    .wdata_i(prv_wdata),
    .raddr_i(rd_addr),
    .rdata_o(prv_rd)
  );

  // top of the free stack is always being read
  assign fs_raddr = SW'(fcnt_q - CW'(1));

  olad_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
    .clk_i  (clk_i),
    .we_i   (fs_we),
    .waddr_i(fcnt_q[SW-1:0]),
    .wdata_i(cur_q),
    .raddr_i(fs_raddr),
    .rdata_o(fs_rd)
  );

  // slots above the high-water mark have never been used
  assign alloc_slot = (fcnt_q != '0) ? fs_rd : hw_q[SW-1:0];
  assign count_m1   = count_q - CW'(1);
  assign match      = (val_rd == val_q);
  assign is_first   = (pos_q == '0);
  assign is_last    = (pos_q == count_m1);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    count_d    = count_q;
    fcnt_d     = fcnt_q;
    hw_d       = hw_q;
    pos_d      = pos_q;
    val_d      = val_q;
    head_val_d = head_val_q;
    tail_val_d = tail_val_q;
    status_d   = status_q;
    fix_head_d = fix_head_q;
    rd_addr    = head_q;
    val_we     = 1'b0;
    val_waddr  = alloc_slot;
    nxt_we     = 1'b0;
    nxt_waddr  = tail_q;
    nxt_wdata  = alloc_slot;
    prv_we     = 1'b0;
    prv_waddr  = alloc_slot;
    prv_wdata  = tail_q;
    fs_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = cmd_word_i.value;
          cur_d = head_q;
          pos_d = '0;
          if (cmd_word_i.cmd == CMD_APPEND) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_APPEND;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_NOMATCH;
              state_d  = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end
        end
      end

      S_APPEND: begin
        val_we = 1'b1;
        prv_we = 1'b1;
        nxt_we = (count_q != '0);
        if (fcnt_q != '0) begin
          fcnt_d = fcnt_q - CW'(1);
        end else begin
          hw_d = hw_q + CW'(1);
        end
        if (count_q == '0) begin
          head_d     = alloc_slot;
          head_val_d = val_q;
        end
        tail_d     = alloc_slot;
        tail_val_d = val_q;
        count_d    = count_q + CW'(1);
        status_d   = ST_DONE;
        state_d    = S_DONE;
      end

      S_WALK: begin
        rd_addr = nxt_rd;
        if (match) begin
          nxt_we    = !is_first;
          nxt_waddr = prv_rd;
          nxt_wdata = nxt_rd;
          prv_we    = !is_last;
          prv_waddr = nxt_rd;
          prv_wdata = prv_rd;
          fs_we     = 1'b1;
          fcnt_d    = fcnt_q + CW'(1);
          count_d   = count_m1;
          status_d  = ST_DONE;
          fix_head_d = is_first;
          priority if (is_first && is_last) begin
            head_d  = '0;
            tail_d  = '0;
            state_d = S_DONE;
          end else if (is_first) begin
            head_d  = nxt_rd;
            state_d = S_FIX;
          end else if (is_last) begin
            // fetch the new tail value
            rd_addr = prv_rd;
            tail_d  = prv_rd;
            state_d = S_FIX;
          end else begin
            state_d = S_DONE;
          end
        end else if (is_last) begin
          status_d = ST_NOMATCH;
          state_d  = S_DONE;
        end else begin
          cur_d = nxt_rd;
          pos_d = pos_q + CW'(1);
        end
      end

      S_FIX: begin
        if (fix_head_q) begin
          head_val_d = val_rd;
        end else begin
          tail_val_d = val_rd;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      cur_q      <= '0;
      count_q    <= '0;
      fcnt_q     <= '0;
      hw_q       <= '0;
      pos_q      <= '0;
      val_q      <= '0;
      head_val_q <= '0;
      tail_val_q <= '0;
      status_q   <= ST_DONE;
      fix_head_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      cur_q      <= cur_d;
      count_q    <= count_d;
      fcnt_q     <= fcnt_d;
      hw_q       <= hw_d;
      pos_q      <= pos_d;
      val_q      <= val_d;
      head_val_q <= head_val_d;
      tail_val_q <= tail_val_d;
      status_q   <= status_d;
      fix_head_q <= fix_head_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_word_o.status     = status_q;
    res_word_o.length     = LEN_W'(count_q);
    res_word_o.head_value = (count_q == '0) ? '0 : head_val_q;
    res_word_o.tail_value = (count_q == '0) ? '0 : tail_val_q;
  end

endmodule

FILE: rtl/core/ordered_list_append_delete.sv
// append: result word registered after S_APPEND and S_DONE; when full, after S_DONE alone
// delete: S_WALK reads one node per cycle from the head, then S_FIX follows when head
//   or tail moves to another node, and the result is registered from S_DONE
// one command at a time; the next word is taken in the cycle after the result is
//   registered, later while out_stall_i holds the previous result
// reset empties the list at once; node memories are not cleared
module ordered_list_append_delete #(
  parameter int unsigned CAPACITY = olad_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  olad_pkg::olad_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output olad_pkg::olad_out_t out_word_o
);

  import olad_pkg::*;

  logic      busy, res_valid, res_ready, in_accept;
  olad_out_t res_word;
  logic      out_valid_q;
  olad_out_t out_word_q;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  olad_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .cmd_word_i (in_word_i),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_word_o (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block not busy after taking a word");

  a_result_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o)
    else $error("finished result not registered");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_FULL |-> out_word_o.length == LEN_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CAPACITY < 128) && out_valid_o && out_word_o.length == '0
      |-> out_word_o.head_value == '0 && out_word_o.tail_value == '0)
    else $error("empty list shows nonzero head or tail");
`endif

endmodule
